@@ design/sorted_timer_queue_scheduler_unit_macros.svh @@
// assertion helpers shared by the scheduler rtl
`ifndef SORTED_TIMER_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define SORTED_TIMER_QUEUE_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define STQS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STQS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/stqs_pkg.sv @@
package stqs_pkg;

  localparam int OUT_TIME_W = 62;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int UNIT_W     = 40;

  // shared multiply / divide unit
  localparam int ARITH_AW = 80;
  localparam int ARITH_BW = 48;
  localparam int ARITH_PW = 128;
  localparam int ARITH_CW = 7;

  localparam logic [13:0] UNITS_PER_MS = 14'd14112;
  localparam logic [15:0] TPS_RESET    = 16'd294;
  localparam logic [12:0] BLK_RESET    = 13'd64;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SAMPLES    = 2'd1;

  localparam logic [2:0] ACT_SET_ABS  = 3'd0;
  localparam logic [2:0] ACT_DELAY    = 3'd1;
  localparam logic [2:0] ACT_UNSET    = 3'd2;
  localparam logic [2:0] ACT_SET_UNIT = 3'd3;
  localparam logic [2:0] ACT_ADVANCE  = 3'd4;

  localparam logic [1:0] EV_ACK     = 2'd0;
  localparam logic [1:0] EV_FIRED   = 2'd1;
  localparam logic [1:0] EV_ADVANCE = 2'd2;

  typedef struct packed {
    logic [2:0]            action;
    logic [4:0]            clock_index;
    logic [OUT_TIME_W-1:0] absolute_time;
    logic [31:0]           amount;
    logic                  sample_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]            event_kind;
    logic [4:0]            fired_clock;
    logic [OUT_TIME_W-1:0] now_time;
  } rsp_t;

  typedef struct packed {
    logic                start;
    logic                is_div;
    logic [ARITH_AW-1:0] a;
    logic [ARITH_BW-1:0] b;
  } arith_cmd_t;

  typedef struct packed {
    logic                done;
    logic [ARITH_PW-1:0] value;
  } arith_res_t;

endpackage

@@ design/stqs_arith.sv @@
module stqs_arith (
  input  logic                clk,
  input  logic                rst,
  input  stqs_pkg::arith_cmd_t cmd,
  output stqs_pkg::arith_res_t res
);

  localparam int AW = stqs_pkg::ARITH_AW;
  localparam int BW = stqs_pkg::ARITH_BW;

  // upper BW+1 bits hold partial sum or remainder, lower AW bits the operand
  logic [AW+BW:0]                p;
  logic [BW-1:0]                 b;
  logic                          is_div;
  logic                          running;
  logic                          done;
  logic [stqs_pkg::ARITH_CW-1:0] cnt;

  logic [AW+BW:0] sh;
  logic [BW:0]    rem;
  logic [BW:0]    sum;
  logic [AW+BW:0] p_next;

  always_comb begin
    sh  = {p[AW+BW-1:0], 1'b0};
    rem = sh[AW+BW:AW];
    sum = p[AW+BW:AW] + (p[0] ? {1'b0, b} : '0);
    if (is_div) begin
      if (rem >= {1'b0, b}) begin
        p_next = {rem - {1'b0, b}, sh[AW-1:1], 1'b1};
      end else begin
        p_next = sh;
      end
    end else begin
      p_next = {1'b0, sum, p[AW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !running) begin
        running <= 1'b1;
        cnt     <= stqs_pkg::ARITH_CW'(AW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == stqs_pkg::ARITH_CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !running) begin
      p      <= {{(BW+1){1'b0}}, cmd.a};
      b      <= cmd.b;
      is_div <= cmd.is_div;
    end else if (running) begin
      p <= p_next;
    end
  end

  assign res.done  = done;
  assign res.value = is_div ? {{(stqs_pkg::ARITH_PW-AW){1'b0}}, p[AW-1:0]}
                            : p[stqs_pkg::ARITH_PW-1:0];

endmodule

@@ design/sorted_timer_queue_scheduler_unit.sv @@
// Timer queue: one item per start pulse, accepted when busy is low; busy stays high
// until the single result strobe, and the result is valid for that one
// cycle only, with no way to hold it off. Unset walks the list links to unlink
// the clock, and set absolute walks them to insert it, unlinking it first when
// the clock is armed. Delay adds one 80-step pass of the shared bit-serial
// multiplier; a unit change on an armed clock adds a divide and a multiply
// through that same unit, so the worst item grows with NUM_CLOCKS. Advance
// takes longer when a clock fires, since that clock is then unlinked. Config
// writes are always ready and must only be issued while busy is low.
`include "sorted_timer_queue_scheduler_unit_macros.svh"

module sorted_timer_queue_scheduler_unit #(
  parameter int NUM_CLOCKS = 32,
  parameter int TIME_WIDTH = 62
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  stqs_pkg::req_t                    request,
  output logic                              result_valid,
  output stqs_pkg::rsp_t                    result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stqs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stqs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IW  = $clog2(NUM_CLOCKS);
  localparam int LKW = $clog2(NUM_CLOCKS + 1);
  localparam int TW  = TIME_WIDTH;
  localparam int UW  = stqs_pkg::UNIT_W;
  localparam int BW  = stqs_pkg::ARITH_BW;
  localparam int AW  = stqs_pkg::ARITH_AW;
  localparam int PW  = stqs_pkg::ARITH_PW;
  localparam logic [LKW-1:0] LINK_END = LKW'(NUM_CLOCKS);

  localparam logic [4:0] S_IDLE        = 5'd0;
  localparam logic [4:0] S_DECODE      = 5'd1;
  localparam logic [4:0] S_U_CHK       = 5'd2;
  localparam logic [4:0] S_DIV_GO      = 5'd3;
  localparam logic [4:0] S_DIV_WAIT    = 5'd4;
  localparam logic [4:0] S_SCALE2      = 5'd5;
  localparam logic [4:0] S_MUL_GO      = 5'd6;
  localparam logic [4:0] S_MUL_WAIT    = 5'd7;
  localparam logic [4:0] S_SAT         = 5'd8;
  localparam logic [4:0] S_INS_START   = 5'd9;
  localparam logic [4:0] S_INS_B       = 5'd10;
  localparam logic [4:0] S_INS_HCHK    = 5'd11;
  localparam logic [4:0] S_INS_WALK_RD = 5'd12;
  localparam logic [4:0] S_INS_WALK_L  = 5'd13;
  localparam logic [4:0] S_INS_WALK_W  = 5'd14;
  localparam logic [4:0] S_INS_LNK1    = 5'd15;
  localparam logic [4:0] S_INS_LNK2    = 5'd16;
  localparam logic [4:0] S_UNL_START   = 5'd17;
  localparam logic [4:0] S_UNL_NX      = 5'd18;
  localparam logic [4:0] S_UNL_WALK_RD = 5'd19;
  localparam logic [4:0] S_UNL_WALK_CH = 5'd20;
  localparam logic [4:0] S_ADV_CHK     = 5'd21;
  localparam logic [4:0] S_DONE        = 5'd22;

  function automatic logic [BW-1:0] scale_of(input logic [UW-1:0] u, input logic s,
                                             input logic [15:0] t);
    logic [UW+15:0] prod;
    prod = u * t;
    return s ? BW'(prod) : BW'({u, 8'b0});
  endfunction

  // config registers
  logic [15:0] tps;
  logic [12:0] blk;

  // control
  logic [4:0]          state;
  logic [TW-1:0]       cur;
  logic [IW-1:0]       head;
  logic                empty;
  logic [NUM_CLOCKS-1:0] armed;
  logic [NUM_CLOCKS-1:0] unit_valid;
  logic                block_open;
  logic [TW-1:0]       block_end;
  logic                ret_ins;
  logic [1:0]          kind;
  logic [IW-1:0]       fired;

  // item and work registers
  logic [2:0]          act;
  logic [IW-1:0]       sx;
  logic                in_rng;
  logic [TW-1:0]       abs_t;
  logic [31:0]         amount;
  logic                samp;
  logic [UW-1:0]       new_unit;
  logic [TW-1:0]       tgt;
  logic [IW-1:0]       p;
  logic [LKW-1:0]      nx;
  logic [AW-1:0]       opa;
  logic [BW-1:0]       scale;
  logic [PW-1:0]       prod;

  // memories
  logic [TW-1:0]  wake_mem [NUM_CLOCKS];
  logic [LKW-1:0] link_mem [NUM_CLOCKS];
  logic [UW:0]    unit_mem [NUM_CLOCKS];
  logic [TW-1:0]  wake_rd;
  logic [LKW-1:0] link_rd;
  logic [UW-1:0]  unit_rd_scale;
  logic           unit_rd_samp;
  logic [IW-1:0]  wake_ra;
  logic [IW-1:0]  link_ra;

  // comb arithmetic
  logic [15:0]   tps_eff;
  logic [31:0]   u_amt;
  logic [45:0]   ms_prod;
  logic [UW-1:0] stored;
  logic [28:0]   blk_len;
  logic [TW:0]   blk_sum;
  logic [TW-1:0] blk_end_sat;
  logic [PW-17:0] dly;
  logic [TW:0]   dly_sum;
  logic [TW-1:0] dly_sat;
  logic [TW-1:0] diff;

  stqs_pkg::arith_cmd_t acmd;
  stqs_pkg::arith_res_t ares;

  stqs_arith u_arith (
    .clk (clk),
    .rst (rst),
    .cmd (acmd),
    .res (ares)
  );

  assign acmd.start  = (state == S_DIV_GO) || (state == S_MUL_GO);
  assign acmd.is_div = (state == S_DIV_GO);
  assign acmd.a      = opa;
  assign acmd.b      = scale;

  always_comb begin
    tps_eff  = (tps == '0) ? 16'd1 : tps;
    u_amt    = (amount == '0) ? 32'd256 : amount;
    ms_prod  = 46'(u_amt) * 46'(stqs_pkg::UNITS_PER_MS);
    stored   = samp ? UW'(u_amt) : UW'(ms_prod >> 8);
    blk_len  = 29'(blk) * 29'(tps_eff);
    blk_sum  = {1'b0, cur} + (TW+1)'(blk_len);
    blk_end_sat = blk_sum[TW] ? '1 : blk_sum[TW-1:0];
    dly      = prod[PW-1:16];
    dly_sum  = {1'b0, cur} + {1'b0, dly[TW-1:0]};
    dly_sat  = ((dly >> TW) != '0 || dly_sum[TW]) ? '1 : dly_sum[TW-1:0];
    diff     = (wake_rd > cur) ? wake_rd - cur : '0;
  end

  always_comb begin
    wake_ra = sx;
    link_ra = sx;
    unique case (state)
      S_DECODE:      wake_ra = (act == stqs_pkg::ACT_ADVANCE) ? head : sx;
      S_INS_B:       wake_ra = head;
      S_INS_WALK_L:  wake_ra = IW'(link_rd);
      S_INS_WALK_RD: link_ra = p;
      S_UNL_WALK_RD: link_ra = p;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    wake_rd       <= wake_mem[wake_ra];
    link_rd       <= link_mem[link_ra];
    unit_rd_scale <= unit_valid[sx] ? unit_mem[sx][UW-1:0] : UW'(stqs_pkg::UNITS_PER_MS);
    unit_rd_samp  <= unit_valid[sx] ? unit_mem[sx][UW] : 1'b0;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= stqs_pkg::TPS_RESET;
      blk <= stqs_pkg::BLK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        stqs_pkg::REG_TICKS_PER_SAMPLE: tps <= cfg_data;
        stqs_pkg::REG_BLOCK_SAMPLES:    blk <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur        <= '0;
      head       <= '0;
      empty      <= 1'b1;
      armed      <= '0;
      unit_valid <= '0;
      block_open <= 1'b0;
      block_end  <= '0;
      ret_ins    <= 1'b0;
      kind       <= stqs_pkg::EV_ACK;
      fired      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act     <= request.action;
            sx      <= IW'(request.clock_index);
            in_rng  <= 32'(request.clock_index) < 32'(NUM_CLOCKS);
            abs_t   <= TW'(request.absolute_time);
            amount  <= request.amount;
            samp    <= request.sample_flag;
            kind    <= stqs_pkg::EV_ACK;
            fired   <= '0;
            ret_ins <= 1'b0;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (act == stqs_pkg::ACT_ADVANCE) begin
            if (!block_open) begin
              block_end  <= blk_end_sat;
              block_open <= 1'b1;
            end
            state <= S_ADV_CHK;
          end else if (!in_rng) begin
            state <= S_DONE;
          end else begin
            case (act)
              stqs_pkg::ACT_SET_ABS: begin
                tgt   <= abs_t;
                state <= S_INS_START;
              end
              stqs_pkg::ACT_DELAY: state <= S_U_CHK;
              stqs_pkg::ACT_UNSET: state <= S_UNL_START;
              stqs_pkg::ACT_SET_UNIT: begin
                new_unit <= stored;
                state    <= S_U_CHK;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_U_CHK: begin
          scale <= scale_of(unit_rd_scale, unit_rd_samp, tps_eff);
          if (act == stqs_pkg::ACT_DELAY) begin
            opa   <= AW'(amount);
            state <= S_MUL_GO;
          end else if (unit_rd_samp == samp && unit_rd_scale == new_unit) begin
            state <= S_DONE;
          end else if (!armed[sx]) begin
            unit_mem[sx]   <= {samp, new_unit};
            unit_valid[sx] <= 1'b1;
            state          <= S_DONE;
          end else begin
            opa   <= AW'({diff, 16'b0});
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (ares.done) begin
            opa   <= ares.value[AW-1:0];
            state <= S_SCALE2;
          end
        end
        S_SCALE2: begin
          unit_mem[sx]   <= {samp, new_unit};
          unit_valid[sx] <= 1'b1;
          scale          <= scale_of(new_unit, samp, tps_eff);
          state          <= S_MUL_GO;
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (ares.done) begin
            prod  <= ares.value;
            state <= S_SAT;
          end
        end
        S_SAT: begin
          tgt   <= dly_sat;
          state <= S_INS_START;
        end
        S_INS_START: begin
          if (tgt < cur) tgt <= cur;
          if (armed[sx]) begin
            ret_ins <= 1'b1;
            state   <= S_UNL_START;
          end else begin
            state <= S_INS_B;
          end
        end
        S_INS_B: begin
          wake_mem[sx] <= tgt;
          armed[sx]    <= 1'b1;
          if (empty) begin
            link_mem[sx] <= LINK_END;
            head         <= sx;
            empty        <= 1'b0;
            state        <= S_DONE;
          end else begin
            state <= S_INS_HCHK;
          end
        end
        S_INS_HCHK: begin
          if (wake_rd <= tgt) begin
            p     <= head;
            state <= S_INS_WALK_RD;
          end else begin
            link_mem[sx] <= LKW'(head);
            head         <= sx;
            state        <= S_DONE;
          end
        end
        S_INS_WALK_RD: state <= S_INS_WALK_L;
        S_INS_WALK_L: begin
          nx    <= link_rd;
          state <= (link_rd >= LINK_END) ? S_INS_LNK1 : S_INS_WALK_W;
        end
        S_INS_WALK_W: begin
          if (wake_rd > tgt) begin
            state <= S_INS_LNK1;
          end else begin
            p     <= IW'(nx);
            state <= S_INS_WALK_RD;
          end
        end
        S_INS_LNK1: begin
          link_mem[sx] <= nx;
          state        <= S_INS_LNK2;
        end
        S_INS_LNK2: begin
          link_mem[p] <= LKW'(sx);
          state       <= S_DONE;
        end
        S_UNL_START: begin
          if (!armed[sx]) begin
            state <= ret_ins ? S_INS_B : S_DONE;
          end else begin
            state <= S_UNL_NX;
          end
        end
        S_UNL_NX: begin
          nx <= link_rd;
          if (head == sx) begin
            if (link_rd >= LINK_END) begin
              empty <= 1'b1;
              head  <= '0;
            end else begin
              head <= IW'(link_rd);
            end
            armed[sx] <= 1'b0;
            state     <= ret_ins ? S_INS_B : S_DONE;
          end else begin
            p     <= head;
            state <= S_UNL_WALK_RD;
          end
        end
        S_UNL_WALK_RD: state <= S_UNL_WALK_CH;
        S_UNL_WALK_CH: begin
          if (link_rd == LKW'(sx)) begin
            link_mem[p] <= nx;
            armed[sx]   <= 1'b0;
            state       <= ret_ins ? S_INS_B : S_DONE;
          end else if (link_rd >= LINK_END) begin
            armed[sx] <= 1'b0;
            state     <= ret_ins ? S_INS_B : S_DONE;
          end else begin
            p     <= IW'(link_rd);
            state <= S_UNL_WALK_RD;
          end
        end
        S_ADV_CHK: begin
          if (!empty && wake_rd < block_end) begin
            cur     <= wake_rd;
            fired   <= head;
            sx      <= head;
            kind    <= stqs_pkg::EV_FIRED;
            ret_ins <= 1'b0;
            state   <= S_UNL_START;
          end else begin
            cur        <= block_end;
            block_open <= 1'b0;
            kind       <= stqs_pkg::EV_ADVANCE;
            state      <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy                = (state != S_IDLE);
  assign result_valid        = (state == S_DONE);
  assign result.event_kind   = kind;
  assign result.fired_clock  = 5'(fired);
  assign result.now_time     = stqs_pkg::OUT_TIME_W'(cur);

  `STQS_ASSERT_NXT(a_done_to_idle, result_valid, !busy, "result not followed by idle")
  `STQS_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
  `STQS_ASSERT_NOW(a_empty_armed, 1'b1, empty == (armed == '0), "list empty flag out of step")
  `STQS_ASSERT_NOW(a_arith_done, ares.done, state == S_DIV_WAIT || state == S_MUL_WAIT,
                   "arith finished outside a wait state")

endmodule

@@ verif/sorted_timer_queue_scheduler_unit_tb.sv @@
`timescale 1ns / 1ps

module sorted_timer_queue_scheduler_unit_tb;

  localparam int NCLK = 32;
  localparam logic [63:0] TMAX = (64'd1 << 62) - 64'd1;
  localparam int LIST_END = NCLK;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int N_DIRECTED = 24;
  // register index with nothing behind it, and two undefined actions
  localparam logic [stqs_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  stqs_pkg::req_t request;
  logic result_valid;
  stqs_pkg::rsp_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [stqs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [stqs_pkg::CFG_DATA_W-1:0] cfg_data;

  sorted_timer_queue_scheduler_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the scheduler
  logic [63:0] now_t;
  int head;
  bit empty;
  bit armed [NCLK];
  logic [63:0] wake [NCLK];
  int link [NCLK];
  logic [63:0] scale [NCLK];
  bit in_samples [NCLK];
  bit blk_open;
  logic [63:0] blk_end;
  logic [15:0] tps;
  logic [12:0] bsamp;

  stqs_pkg::rsp_t pending_events [$];
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(string what, stqs_pkg::rsp_t e, stqs_pkg::rsp_t a);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected kind %0d clock %0d now %0d, %s %0d %s %0d %s %0d",
               what, e.event_kind, e.fired_clock, e.now_time,
               "got kind", a.event_kind, "clock", a.fired_clock, "now", a.now_time);
  endtask

  always @(posedge clk) begin
    stqs_pkg::rsp_t e;
    if (!rst && result_valid) begin
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result, now %0d", result.now_time);
      end else begin
        e = pending_events.pop_front();
        if (e !== result) note_mismatch("result", e, result);
      end
    end
  end

  function automatic logic [63:0] tps_eff();
    return (tps == 0) ? 64'd1 : {48'd0, tps};
  endfunction

  function automatic logic [63:0] eff_scale(int x);
    return in_samples[x] ? scale[x] * tps_eff() : scale[x] << 8;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [127:0] b);
    logic [63:0] s;
    if (b > {64'd0, TMAX}) return TMAX;
    s = a + b[63:0];
    return (s > TMAX) ? TMAX : s;
  endfunction

  function automatic void unlink_clock(int x);
    int p;
    if (!armed[x]) return;
    if (head == x) begin
      if (link[x] >= LIST_END) begin
        empty = 1;
        head = 0;
      end else begin
        head = link[x];
      end
    end else begin
      p = head;
      for (int n = 0; n < NCLK; n++) begin
        if (p >= NCLK || link[p] == x) break;
        p = link[p];
      end
      if (p < NCLK && link[p] == x) link[p] = link[x];
    end
    armed[x] = 0;
  endfunction

  function automatic void insert_clock(int x, logic [63:0] t);
    int p;
    int q;
    if (t < now_t) t = now_t;
    unlink_clock(x);
    wake[x] = t;
    armed[x] = 1;
    if (!empty && wake[head] <= t) begin
      p = head;
      for (int n = 0; n < NCLK; n++) begin
        q = link[p];
        if (q >= NCLK || wake[q] > t) break;
        p = q;
      end
      link[x] = link[p];
      link[p] = x;
    end else begin
      link[x] = empty ? LIST_END : head;
      head = x;
      empty = 0;
    end
  endfunction

  function automatic void reset_schedule();
    tps = stqs_pkg::TPS_RESET;
    bsamp = stqs_pkg::BLK_RESET;
    now_t = 0;
    head = 0;
    empty = 1;
    blk_open = 0;
    blk_end = 0;
    for (int i = 0; i < NCLK; i++) begin
      armed[i] = 0;
      wake[i] = 0;
      link[i] = 0;
      scale[i] = 64'(stqs_pkg::UNITS_PER_MS);
      in_samples[i] = 0;
    end
  endfunction

  function automatic stqs_pkg::rsp_t schedule_step(stqs_pkg::req_t r);
    stqs_pkg::rsp_t o;
    int x;
    int c;
    logic [63:0] u;
    logic [63:0] stored;
    logic [63:0] diff;
    logic [127:0] left;
    logic [127:0] prod;
    bit was_armed;
    x = int'(r.clock_index);
    o.event_kind = stqs_pkg::EV_ACK;
    o.fired_clock = '0;
    if (r.action == stqs_pkg::ACT_ADVANCE) begin
      if (!blk_open) begin
        blk_end = sat_add(now_t, {115'd0, bsamp} * {64'd0, tps_eff()});
        blk_open = 1;
      end
      if (!empty && wake[head] < blk_end) begin
        c = head;
        now_t = wake[c];
        unlink_clock(c);
        o.event_kind = stqs_pkg::EV_FIRED;
        o.fired_clock = c[4:0];
      end else begin
        now_t = blk_end;
        blk_open = 0;
        o.event_kind = stqs_pkg::EV_ADVANCE;
      end
    end else if (r.action == stqs_pkg::ACT_SET_ABS) begin
      insert_clock(x, {2'b00, r.absolute_time});
    end else if (r.action == stqs_pkg::ACT_DELAY) begin
      prod = {96'd0, r.amount} * {64'd0, eff_scale(x)};
      insert_clock(x, sat_add(now_t, prod >> 16));
    end else if (r.action == stqs_pkg::ACT_UNSET) begin
      unlink_clock(x);
    end else if (r.action == stqs_pkg::ACT_SET_UNIT) begin
      u = (r.amount == 0) ? 64'd256 : {32'd0, r.amount};
      stored = r.sample_flag ? u : (u * 64'(stqs_pkg::UNITS_PER_MS)) >> 8;
      if (!(in_samples[x] == r.sample_flag && scale[x] == stored)) begin
        was_armed = armed[x];
        left = 0;
        if (was_armed) begin
          diff = (wake[x] > now_t) ? wake[x] - now_t : 64'd0;
          left = ({64'd0, diff} << 16) / {64'd0, eff_scale(x)};
        end
        in_samples[x] = r.sample_flag;
        scale[x] = stored;
        if (was_armed) begin
          prod = left * {64'd0, eff_scale(x)};
          insert_clock(x, sat_add(now_t, prod >> 16));
        end
      end
    end
    o.now_time = now_t[61:0];
    return o;
  endfunction

  function automatic stqs_pkg::req_t mk(logic [2:0] a, logic [4:0] i, logic [61:0] t,
                                        logic [31:0] amt, logic f);
    stqs_pkg::req_t r;
    r.action = a;
    r.clock_index = i;
    r.absolute_time = t;
    r.amount = amt;
    r.sample_flag = f;
    return r;
  endfunction

  function automatic stqs_pkg::rsp_t ev(logic [1:0] k, logic [4:0] c, logic [61:0] t);
    stqs_pkg::rsp_t o;
    o.event_kind = k;
    o.fired_clock = c;
    o.now_time = t;
    return o;
  endfunction

  // issue one item and hold start until it is taken
  task automatic issue(stqs_pkg::req_t r, bit chk, stqs_pkg::rsp_t typed);
    stqs_pkg::rsp_t p;
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    p = schedule_step(r);
    if (chk && p !== typed) note_mismatch("directed row", typed, p);
    pending_events.push_back(p);
  endtask

  task automatic idle_gap(bit quiet);
    int g;
    g = 0;
    if (!quiet && $urandom_range(0, 9) >= 6)
      g = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [stqs_pkg::CFG_IDX_W-1:0] idx,
                           logic [stqs_pkg::CFG_DATA_W-1:0] val);
    start <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == stqs_pkg::REG_TICKS_PER_SAMPLE) tps = val;
    else if (idx == stqs_pkg::REG_BLOCK_SAMPLES) bsamp = val[12:0];
  endtask

  function automatic stqs_pkg::req_t random_item();
    stqs_pkg::req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.clock_index = 5'($urandom_range(0, NCLK - 1));
    r.sample_flag = 1'($urandom_range(0, 1));
    r.absolute_time = 62'({$urandom, $urandom}) & TMAX[61:0];
    r.amount = $urandom;
    if (pick < 30) begin
      r.action = stqs_pkg::ACT_ADVANCE;
    end else if (pick < 50) begin
      r.action = stqs_pkg::ACT_SET_ABS;
      if ($urandom_range(0, 19) != 0)
        r.absolute_time = now_t[61:0] + 62'($urandom_range(0, 60000)) - 62'd5000;
    end else if (pick < 68) begin
      r.action = stqs_pkg::ACT_DELAY;
      if ($urandom_range(0, 19) != 0) r.amount = $urandom_range(0, 4096);
    end else if (pick < 80) begin
      r.action = stqs_pkg::ACT_UNSET;
    end else if (pick < 97) begin
      r.action = stqs_pkg::ACT_SET_UNIT;
      if ($urandom_range(0, 9) != 0) r.amount = $urandom_range(0, 1024);
    end else begin
      r.action = 3'($urandom_range(32'(ACT_UNDEF_LO), 32'(ACT_UNDEF_HI)));
    end
    return r;
  endfunction

  stqs_pkg::req_t dir_req [N_DIRECTED];
  bit dir_chk [N_DIRECTED];
  stqs_pkg::rsp_t dir_exp [N_DIRECTED];

  initial begin
    bit quiet;
    logic [15:0] tps_set [5];
    logic [15:0] blk_set [5];
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_schedule();
    for (int i = 0; i < N_DIRECTED; i++) begin
      dir_chk[i] = 0;
      dir_exp[i] = '0;
    end
    // empty list: the first advance just closes a default block
    dir_req[0] = mk(stqs_pkg::ACT_ADVANCE, 0, 0, 0, 0);
    dir_chk[0] = 1; dir_exp[0] = ev(stqs_pkg::EV_ADVANCE, 0, 62'd18816);
    // wake in the past is raised to now
    dir_req[1] = mk(stqs_pkg::ACT_SET_ABS, 0, 0, 0, 0);
    dir_chk[1] = 1; dir_exp[1] = ev(stqs_pkg::EV_ACK, 0, 62'd18816);
    dir_req[2] = mk(stqs_pkg::ACT_ADVANCE, 0, 0, 0, 0);
    dir_chk[2] = 1; dir_exp[2] = ev(stqs_pkg::EV_FIRED, 0, 62'd18816);
    dir_req[3] = mk(stqs_pkg::ACT_SET_ABS, 31, TMAX[61:0], 0, 0);
    dir_chk[3] = 1; dir_exp[3] = ev(stqs_pkg::EV_ACK, 0, 62'd18816);
    dir_req[4] = mk(stqs_pkg::ACT_DELAY, 1, 0, 32'd0, 0);
    dir_req[5] = mk(stqs_pkg::ACT_DELAY, 2, 0, 32'hffff_ffff, 0);
    dir_req[6] = mk(stqs_pkg::ACT_SET_UNIT, 3, 0, 32'd0, 1);
    dir_req[7] = mk(stqs_pkg::ACT_SET_UNIT, 1, 0, 32'd256, 0);
    dir_req[8] = mk(stqs_pkg::ACT_SET_UNIT, 2, 0, 32'h80, 1);
    dir_req[9] = mk(stqs_pkg::ACT_UNSET, 31, 0, 0, 0);
    dir_req[10] = mk(stqs_pkg::ACT_UNSET, 5, 0, 0, 0);
    dir_req[11] = mk(ACT_UNDEF_LO, 6, TMAX[61:0], 32'hffff_ffff, 1);
    dir_chk[11] = 1; dir_exp[11] = ev(stqs_pkg::EV_ACK, 0, 62'd18816);
    dir_req[12] = mk(ACT_UNDEF_HI, 7, 0, 0, 0);
    dir_chk[12] = 1; dir_exp[12] = ev(stqs_pkg::EV_ACK, 0, 62'd18816);
    // equal wake times leave in arrival order
    dir_req[13] = mk(stqs_pkg::ACT_SET_ABS, 9, 62'd20000, 0, 0);
    dir_req[14] = mk(stqs_pkg::ACT_SET_ABS, 4, 62'd20000, 0, 0);
    dir_req[15] = mk(stqs_pkg::ACT_SET_ABS, 8, 62'd19000, 0, 0);
    dir_req[16] = mk(stqs_pkg::ACT_DELAY, 3, 0, 32'd512, 1);
    dir_req[17] = mk(stqs_pkg::ACT_SET_UNIT, 3, 0, 32'd100, 0);
    for (int i = 18; i < N_DIRECTED; i++) dir_req[i] = mk(stqs_pkg::ACT_ADVANCE, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue(dir_req[i], dir_chk[i], dir_exp[i]);
      idle_gap(0);
    end

    tps_set = '{16'd1, 16'd65535, 16'd0, 16'd294, 16'($urandom_range(1, 2000))};
    blk_set = '{16'd1, 16'd4096, 16'd0, 16'd8191, 16'($urandom_range(1, 300))};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(stqs_pkg::REG_TICKS_PER_SAMPLE, tps_set[ph]);
      write_reg(stqs_pkg::REG_BLOCK_SAMPLES, blk_set[ph]);
      if (ph == 2) write_reg(REG_NONE, 16'hffff);
      quiet = (ph == 1);
      for (int n = 0; n < 200; n++) begin
        issue(random_item(), 0, '0);
        idle_gap(quiet);
      end
    end

    start <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/stqs_pkg.sv
design/stqs_arith.sv
design/sorted_timer_queue_scheduler_unit.sv
verif/sorted_timer_queue_scheduler_unit_tb.sv
